>>> design/sparse_set_membership_defines.svh
// Assertion macros shared by the checker of the sparse set block.
`ifndef SPARSE_SET_MEMBERSHIP_DEFINES_SVH
`define SPARSE_SET_MEMBERSHIP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse set check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse set check failed");

`endif

>>> design/ssm_pkg.sv
// Package with the sizes, codes and controller types of the sparse set block.
package ssm_pkg;

  localparam int ID_COUNT = 1024;
  localparam int ID_W = $clog2(ID_COUNT);
  localparam int CNT_W = $clog2(ID_COUNT + 1);

  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ssm_cmd_t;

  typedef struct packed {
    logic clear_done;
  } ssm_stat_t;

endpackage

>>> design/ssm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ssm_ctrl.sv
// Controller state machine: clearing pass, request acceptance and execution.
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ssm_stat_t stat,
  output ssm_cmd_t  cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> design/ssm_datapath.sv
// Datapath: membership, sparse map and dense list RAMs, member count and result registers.
module ssm_datapath
  import ssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ssm_cmd_t         cmd,
  input  logic [1:0]       mode,
  input  logic [ID_W-1:0]  id,
  output ssm_stat_t        stat,
  output logic             strobe,
  output logic             found,
  output logic [ID_W-1:0]  slot,
  output logic [CNT_W-1:0] member_count
);

  logic [1:0]       mode_q;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [ID_W-1:0]  clr_addr;

  logic             valid_rd;
  logic [ID_W-1:0]  slot_rd;
  logic [ID_W-1:0]  moved_rd;

  logic             id_ok;
  logic             present;
  logic             do_add;
  logic             do_rem;
  logic [ID_W-1:0]  last_addr;

  logic             valid_we;
  logic [ID_W-1:0]  valid_waddr;
  logic             valid_wdata;
  logic             sid_we;
  logic [ID_W-1:0]  sid_waddr;
  logic [ID_W-1:0]  sid_wdata;
  logic             ias_we;
  logic [ID_W-1:0]  ias_waddr;
  logic [ID_W-1:0]  ias_wdata;

  assign last_addr = ID_W'(count - CNT_W'(1));
  assign id_ok = ({1'b0, id_q} < (ID_W + 1)'(ID_COUNT));
  assign present = valid_rd && id_ok;
  assign do_add = cmd.exec && (mode_q == MODE_ADD) && !present && id_ok &&
                  (count < CNT_W'(ID_COUNT));
  assign do_rem = cmd.exec && (mode_q == MODE_REMOVE) && present;
  assign stat.clear_done = (clr_addr == ID_W'(ID_COUNT - 1));

  always_comb begin
    count_next = count;
    if (do_add) begin
      count_next = count + CNT_W'(1);
    end else if (do_rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    valid_we = cmd.clear || do_add || do_rem;
    valid_waddr = cmd.clear ? clr_addr : id_q;
    valid_wdata = do_add;
    sid_we = do_add || do_rem;
    sid_waddr = do_add ? id_q : moved_rd;
    sid_wdata = do_add ? ID_W'(count) : slot_rd;
    ias_we = do_add || do_rem;
    ias_waddr = do_add ? ID_W'(count) : slot_rd;
    ias_wdata = do_add ? id_q : moved_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr_addr <= '0;
      strobe <= 1'b0;
    end else begin
      count <= count_next;
      strobe <= cmd.exec;
      if (cmd.clear) begin
        clr_addr <= clr_addr + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      id_q <= id;
    end
    if (cmd.exec) begin
      found <= present;
      slot <= present ? slot_rd : '0;
      member_count <= count_next;
    end
  end

  ssm_ram #(
    .WIDTH(1),
    .DEPTH(ID_COUNT)
  ) u_valid_ram (
    .clk  (clk),
    .we   (valid_we),
    .waddr(valid_waddr),
    .wdata(valid_wdata),
    .re   (cmd.load),
    .raddr(id),
    .rdata(valid_rd)
  );

  ssm_ram #(
    .WIDTH(ID_W),
    .DEPTH(ID_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (sid_we),
    .waddr(sid_waddr),
    .wdata(sid_wdata),
    .re   (cmd.load),
    .raddr(id),
    .rdata(slot_rd)
  );

  ssm_ram #(
    .WIDTH(ID_W),
    .DEPTH(ID_COUNT)
  ) u_dense_ram (
    .clk  (clk),
    .we   (ias_we),
    .waddr(ias_waddr),
    .wdata(ias_wdata),
    .re   (cmd.load),
    .raddr(last_addr),
    .rdata(moved_rd)
  );

endmodule

>>> design/sparse_set_membership.sv
// Top level of the sparse set: controller and datapath joined by command and status.
// Each request has two steps: the RAM read on acceptance, then the update in EXEC.
// The result strobe is registered from the execute command of the EXEC state after acceptance.
// Requests do not overlap: after the RAM read on acceptance, busy stays high through its write.
// After reset, busy stays high while all ID_COUNT entries of the membership RAM are cleared.
module sparse_set_membership
  import ssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode,
  input  logic [ID_W-1:0]  id,
  output logic             strobe,
  output logic             found,
  output logic [ID_W-1:0]  slot,
  output logic [CNT_W-1:0] member_count
);

  ssm_cmd_t  cmd;
  ssm_stat_t stat;

  ssm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  ssm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .id          (id),
    .stat        (stat),
    .strobe      (strobe),
    .found       (found),
    .slot        (slot),
    .member_count(member_count)
  );

endmodule

>>> design/ssm_checker.sv
// Port-level checker for the sparse set block and its bind to the top level.
`include "sparse_set_membership_defines.svh"

module ssm_checker
  import ssm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             strobe,
  input logic             found,
  input logic [ID_W-1:0]  slot,
  input logic [CNT_W-1:0] member_count
);

  `SSM_ASSERT_NEXT(busy_after_accept, start && !busy, busy)
  `SSM_ASSERT_IMP(result_follows_request, start && !busy, ##2 strobe)
  `SSM_ASSERT_NEXT(single_result_strobe, strobe, !strobe)
  `SSM_ASSERT_IMP(slot_zero_when_absent, strobe && !found, slot == '0)
  `SSM_ASSERT_IMP(count_within_range, strobe, member_count <= CNT_W'(ID_COUNT))

endmodule

bind sparse_set_membership ssm_checker u_checker (.*);

>>> tb/sparse_set_membership_tb.sv
// Self-checking testbench for the sparse set block: queued requests, predicted replies.
`timescale 1ns / 100ps

module sparse_set_membership_tb;
  import ssm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TOTAL_REQUESTS = 1300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [1:0]      mode;
    logic [ID_W-1:0] id;
    int              gap;
  } request_t;

  typedef struct {
    logic             found;
    logic [ID_W-1:0]  slot;
    logic [CNT_W-1:0] member_count;
  } reply_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       mode = MODE_QUERY;
  logic [ID_W-1:0]  id = '0;
  logic             busy;
  logic             strobe;
  logic             found;
  logic [ID_W-1:0]  slot;
  logic [CNT_W-1:0] member_count;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  logic             is_member[ID_COUNT];
  logic [ID_W-1:0]  dense_slot_of[ID_COUNT];
  logic [ID_W-1:0]  id_in_slot[ID_COUNT];
  logic [CNT_W-1:0] set_size;

  sparse_set_membership uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .id(id),
    .strobe(strobe),
    .found(found),
    .slot(slot),
    .member_count(member_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reply_t apply_request(logic [1:0] op, logic [ID_W-1:0] key);
    reply_t r;
    logic [ID_W-1:0] moved_id;
    r.found = is_member[key];
    r.slot = is_member[key] ? dense_slot_of[key] : '0;
    if (op == MODE_ADD && !is_member[key] && set_size < ID_COUNT) begin
      dense_slot_of[key] = set_size[ID_W-1:0];
      id_in_slot[set_size[ID_W-1:0]] = key;
      is_member[key] = 1'b1;
      set_size = set_size + 1'b1;
    end else if (op == MODE_REMOVE && is_member[key] && set_size > 0) begin
      moved_id = id_in_slot[ID_W'(set_size - 1'b1)];
      id_in_slot[r.slot] = moved_id;
      dense_slot_of[moved_id] = r.slot;
      is_member[key] = 1'b0;
      set_size = set_size - 1'b1;
    end
    r.member_count = set_size;
    return r;
  endfunction

  task automatic push_request(logic [1:0] op, logic [ID_W-1:0] key, int gap);
    request_t req;
    req.mode = op;
    req.id = key;
    req.gap = gap;
    pending_requests.push_back(req);
  endtask

  always @(posedge clk) begin : drive
    logic accepted;
    logic loaded;
    int   hold_left;
    if (rst) begin
      start <= 1'b0;
      loaded = 1'b0;
      hold_left = 0;
      set_size = '0;
      for (int i = 0; i < ID_COUNT; i++) begin
        is_member[i] = 1'b0;
        dense_slot_of[i] = '0;
        id_in_slot[i] = '0;
      end
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_replies.push_back(apply_request(mode, id));
        void'(pending_requests.pop_front());
        loaded = 1'b0;
      end
      if (start && !accepted) begin
        // The current request is held until the block takes it.
      end else if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!loaded) begin
          hold_left = pending_requests[0].gap;
          loaded = 1'b1;
        end
        if (hold_left > 0) begin
          hold_left--;
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          mode <= pending_requests[0].mode;
          id <= pending_requests[0].id;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    reply_t want;
    if (!rst && strobe) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: found %0d slot %0d member_count %0d",
               found, slot, member_count);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          mismatch_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          mismatch_count++;
        end
        if (member_count !== want.member_count) begin
          $error("member_count: expected %0d, actual %0d", want.member_count, member_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int burst_left;
    int pool_base;
    int roll;
    logic [1:0] op;
    logic [ID_W-1:0] key;

    // Directed: empty set, both ends of the id range, duplicates, swap and pop.
    push_request(MODE_QUERY, 10'd0, 0);
    push_request(MODE_REMOVE, 10'd0, 0);
    push_request(MODE_ADD, 10'd0, 0);
    push_request(MODE_ADD, 10'd1023, 1);
    push_request(MODE_ADD, 10'd0, 0);
    push_request(MODE_QUERY, 10'd1023, 2);
    push_request(MODE_QUERY, 10'd0, 0);
    push_request(MODE_REMOVE, 10'd1023, 0);
    push_request(MODE_REMOVE, 10'd1023, 3);
    push_request(MODE_ADD, 10'h2AA, 0);
    push_request(MODE_ADD, 10'h155, 0);
    push_request(MODE_ADD, 10'd1023, 0);
    push_request(MODE_REMOVE, 10'd0, 1);
    push_request(MODE_QUERY, 10'd1023, 0);
    push_request(MODE_QUERY, 10'h155, 0);
    push_request(MODE_UNUSED, 10'h2AA, 0);
    push_request(MODE_UNUSED, 10'd7, 2);
    push_request(MODE_REMOVE, 10'h2AA, 0);
    push_request(MODE_QUERY, 10'd1023, 0);
    push_request(MODE_REMOVE, 10'd1023, 0);
    push_request(MODE_REMOVE, 10'h155, 0);
    push_request(MODE_QUERY, 10'h155, 0);
    push_request(MODE_ADD, 10'h155, 4);

    burst_left = 0;
    pool_base = 0;
    while (pending_requests.size() < TOTAL_REQUESTS) begin
      if (pending_requests.size() % 150 == 0)
        pool_base = $urandom_range(0, ID_COUNT - 64);
      roll = $urandom_range(0, 99);
      if (roll < 45) op = MODE_ADD;
      else if (roll < 75) op = MODE_REMOVE;
      else if (roll < 95) op = MODE_QUERY;
      else op = MODE_UNUSED;
      if ($urandom_range(0, 99) < 75)
        key = ID_W'(pool_base + $urandom_range(0, 63));
      else
        key = ID_W'($urandom_range(0, ID_COUNT - 1));
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        push_request(op, key, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end else begin
        push_request(op, key, 0);
      end
      burst_left--;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
